// ===== rtl/irpd_pkg.sv =====
// irpd_pkg: shared types, constants and window functions for the ir remote pulse decoder
// used by irpd_window_match and ir_remote_pulse_decoder; no dependencies
`default_nettype none

package irpd_pkg;

    // field widths
    localparam int TIME_W  = 32;
    localparam int GAP_W   = 16;
    localparam int UNIT_W  = 12;
    localparam int SHIFT_W = 32;
    localparam int CNT_W   = 6;
    localparam int CODE_W  = 16;
    localparam int CHAN_W  = 2;
    localparam int EV_W    = 2;
    localparam int WIN_W   = 18;

    // reset values of the unit registers
    localparam logic [UNIT_W-1:0] NEC_UNIT_RST = 12'd562;
    localparam logic [UNIT_W-1:0] ANA_UNIT_RST = 12'd350;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_NEC_UNIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANA_UNIT = 2'd1;

    // event codes
    localparam logic [EV_W-1:0] EV_NONE   = 2'd0;
    localparam logic [EV_W-1:0] EV_NEC    = 2'd1;
    localparam logic [EV_W-1:0] EV_REPEAT = 2'd2;
    localparam logic [EV_W-1:0] EV_ANALOG = 2'd3;

    // nec frame constants
    localparam logic [CNT_W-1:0]   NEC_FRAME_BITS = 6'd32;
    localparam logic [SHIFT_W-1:0] NEC_CPL_MASK   = 32'h00FF00FF;

    // decoder phase, one-hot
    typedef enum logic [6:0] {
        PH_H_IDLE = 7'b0000001,
        PH_H_HDR  = 7'b0000010,
        PH_H_BIT  = 7'b0000100,
        PH_H_ANA  = 7'b0001000,
        PH_L_HDR  = 7'b0010000,
        PH_L_BIT  = 7'b0100000,
        PH_L_ANA  = 7'b1000000
    } phase_t;

    // window hits for the current gap
    typedef struct packed {
        logic nec16;
        logic nec8;
        logic nec4;
        logic nec3;
        logic nec1;
        logic ana3;
        logic ana2;
        logic ana1;
    } match_t;

    // gap within d - tol .. d + tol
    function automatic logic win_hit(
        input logic [WIN_W-1:0] gap,
        input logic [WIN_W-1:0] d,
        input logic [WIN_W-1:0] tol
    );
        win_hit = ((gap + tol) >= d) && (gap <= (d + tol));
    endfunction

    // nec window, tolerance d/4 + 1
    function automatic logic nec_hit(
        input logic [WIN_W-1:0] gap,
        input logic [WIN_W-1:0] d
    );
        nec_hit = win_hit(gap, d, (d >> 2) + 18'd1);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ir_remote_pulse_decoder.sv =====
// ir remote pulse decoder: one result per edge request; the result is registered behind
// its input accept edge (input register, then result register), with the phase update
// between the two registers; one edge per cycle sustained while m_tready stays high;
// input stalls only while both registers hold a request and m_tready is low
// reset: phase idle awaiting a falling edge, all decoder state zero, units 562 / 350
`default_nettype none

module ir_remote_pulse_decoder #(
    parameter int ANALOG_FRAME_BITS = 15
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // edge requests
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] time_us
    input  wire logic        s_tuser,   // [0] rising
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [0] accepted, [1] expect_rising, [17:2] code,
                                        // [19:18] channel, [23:20] zero
    output logic [1:0]       m_tuser,   // [1:0] event_res
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [11:0] cfg_wdata
);

    localparam logic [irpd_pkg::CNT_W-1:0] ANA_EDGES =
        irpd_pkg::CNT_W'(2 * ANALOG_FRAME_BITS);

    // configuration registers
    logic [irpd_pkg::UNIT_W-1:0] nec_unit_reg;
    logic [irpd_pkg::UNIT_W-1:0] ana_unit_reg;

    // input register
    logic                        in_valid_reg;
    logic                        in_rising_reg;
    logic [irpd_pkg::TIME_W-1:0] in_time_reg;

    // decoder state
    irpd_pkg::phase_t             phase_reg, phase_next;
    logic [irpd_pkg::TIME_W-1:0]  last_reg, last_next;
    logic [irpd_pkg::SHIFT_W-1:0] shift_reg, shift_next;
    logic [irpd_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [irpd_pkg::CODE_W-1:0]  held_reg, held_next;
    logic [irpd_pkg::CHAN_W-1:0]  chan_reg, chan_next;

    // result register
    logic                         out_valid_reg;
    logic                         out_acc_reg;
    logic                         out_exp_reg;
    logic [irpd_pkg::EV_W-1:0]    out_ev_reg;
    logic [irpd_pkg::CODE_W-1:0]  out_code_reg;
    logic [irpd_pkg::CHAN_W-1:0]  out_chan_reg;

    logic                         advance;
    logic                         exp_rising;
    logic                         take;
    logic                         cpl_ok;
    logic [irpd_pkg::TIME_W-1:0]  span;
    logic [irpd_pkg::GAP_W-1:0]   gap;
    logic [irpd_pkg::EV_W-1:0]    ev;
    logic [irpd_pkg::SHIFT_W-1:0] ana_shift;
    logic [irpd_pkg::CNT_W-1:0]   ana_count;
    logic [irpd_pkg::CODE_W-1:0]  frame;
    logic [irpd_pkg::CHAN_W-1:0]  frame_chan;
    irpd_pkg::match_t             hits;

    // handshake: the input stage moves when the result register is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nec_unit_reg <= irpd_pkg::NEC_UNIT_RST;
            ana_unit_reg <= irpd_pkg::ANA_UNIT_RST;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == irpd_pkg::REG_NEC_UNIT)
                nec_unit_reg <= cfg_wdata;
            else if (cfg_index == irpd_pkg::REG_ANA_UNIT)
                ana_unit_reg <= cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_rising_reg <= s_tuser;
            in_time_reg   <= s_tdata;
        end
    end

    // polarity expected by the current phase
    assign exp_rising = (phase_reg == irpd_pkg::PH_L_HDR) ||
                        (phase_reg == irpd_pkg::PH_L_BIT) ||
                        (phase_reg == irpd_pkg::PH_L_ANA);
    assign take = advance && (in_rising_reg == exp_rising);

    // saturated gap since the last accepted edge
    assign span = in_time_reg - last_reg;
    assign gap  = (span[irpd_pkg::TIME_W-1:irpd_pkg::GAP_W] != '0) ? '1
                                                                   : span[irpd_pkg::GAP_W-1:0];

    irpd_window_match u_match (
        .gap      (gap),
        .nec_unit (nec_unit_reg),
        .ana_unit (ana_unit_reg),
        .hits     (hits)
    );

    // nec address and command complement check
    assign cpl_ok = (((shift_reg >> 8) ^ shift_reg) & irpd_pkg::NEC_CPL_MASK)
                    == irpd_pkg::NEC_CPL_MASK;

    // analog pulse step: short pulse adds a one on even counts, long pulse a zero
    always_comb
    begin
        ana_shift = shift_reg;
        ana_count = count_reg;
        if (hits.ana1)
        begin
            if (!count_reg[0])
                ana_shift = {shift_reg[irpd_pkg::SHIFT_W-2:0], 1'b1};
            ana_count = count_reg + 6'd1;
        end
        else if (hits.ana2)
        begin
            ana_shift = {shift_reg[irpd_pkg::SHIFT_W-2:0], 1'b0};
            ana_count = count_reg + 6'd2;
        end
    end

    assign frame      = ana_shift[irpd_pkg::CODE_W-1:0];
    assign frame_chan = frame[14:13];

    // phase machine
    always_comb
    begin
        phase_next = phase_reg;
        last_next  = last_reg;
        shift_next = shift_reg;
        count_next = count_reg;
        held_next  = held_reg;
        chan_next  = chan_reg;
        ev         = irpd_pkg::EV_NONE;
        if (take)
        begin
            last_next = in_time_reg;
            case (phase_reg)
                irpd_pkg::PH_L_HDR:
                begin
                    if (hits.nec16)
                        phase_next = irpd_pkg::PH_H_HDR;
                    else if (hits.ana3)
                    begin
                        shift_next = '0;
                        count_next = '0;
                        phase_next = irpd_pkg::PH_H_ANA;
                    end
                    else
                        phase_next = irpd_pkg::PH_H_IDLE;
                end
                irpd_pkg::PH_H_HDR:
                begin
                    phase_next = irpd_pkg::PH_H_IDLE;
                    if (hits.nec8)
                    begin
                        shift_next = '0;
                        count_next = '0;
                        phase_next = irpd_pkg::PH_L_BIT;
                    end
                    else if (hits.nec4 && (held_reg != '0))
                        ev = irpd_pkg::EV_REPEAT;
                end
                irpd_pkg::PH_L_BIT:
                begin
                    phase_next = irpd_pkg::PH_H_IDLE;
                    if (hits.nec1)
                    begin
                        if (count_reg < irpd_pkg::NEC_FRAME_BITS)
                            phase_next = irpd_pkg::PH_H_BIT;
                        else if (cpl_ok)
                        begin
                            held_next = {8'd0, shift_reg[23:16]};
                            ev        = irpd_pkg::EV_NEC;
                        end
                    end
                end
                irpd_pkg::PH_H_BIT:
                begin
                    phase_next = irpd_pkg::PH_L_BIT;
                    count_next = count_reg + 6'd1;
                    shift_next = {hits.nec3, shift_reg[irpd_pkg::SHIFT_W-1:1]};
                    if (!hits.nec3 && !hits.nec1)
                        phase_next = irpd_pkg::PH_H_IDLE;
                end
                irpd_pkg::PH_H_ANA, irpd_pkg::PH_L_ANA:
                begin
                    if (!hits.ana1 && !hits.ana2)
                        phase_next = irpd_pkg::PH_H_IDLE;
                    else
                    begin
                        shift_next = ana_shift;
                        count_next = ana_count;
                        if (ana_count < ANA_EDGES)
                            phase_next = (phase_reg == irpd_pkg::PH_L_ANA) ?
                                         irpd_pkg::PH_H_ANA : irpd_pkg::PH_L_ANA;
                        else
                        begin
                            phase_next = irpd_pkg::PH_H_IDLE;
                            if (chan_reg == '0)
                                chan_next = frame_chan;
                            else if (frame_chan == chan_reg)
                            begin
                                held_next = frame;
                                ev        = irpd_pkg::EV_ANALOG;
                            end
                        end
                    end
                end
                default:
                    phase_next = irpd_pkg::PH_L_HDR;
            endcase
        end
    end

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= irpd_pkg::PH_H_IDLE;
            last_reg  <= '0;
            shift_reg <= '0;
            count_reg <= '0;
            held_reg  <= '0;
            chan_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            last_reg  <= last_next;
            shift_reg <= shift_next;
            count_reg <= count_next;
            held_reg  <= held_next;
            chan_reg  <= chan_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_acc_reg  <= take;
            out_exp_reg  <= (phase_next == irpd_pkg::PH_L_HDR) ||
                            (phase_next == irpd_pkg::PH_L_BIT) ||
                            (phase_next == irpd_pkg::PH_L_ANA);
            out_ev_reg   <= ev;
            out_code_reg <= held_next;
            out_chan_reg <= chan_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_chan_reg, out_code_reg, out_exp_reg, out_acc_reg};
    assign m_tuser  = out_ev_reg;

`ifndef SYNTHESIS
    // an empty result register never blocks new requests
    assert property (@(posedge clk) disable iff (!rst_n) !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // events come only from accepted edges
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != irpd_pkg::EV_NONE) |-> m_tdata[0])
        else $error("event reported for an ignored edge");

    // a repeat needs a held code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == irpd_pkg::EV_REPEAT) |-> (m_tdata[17:2] != '0))
        else $error("repeat reported without held code");

    // an analog frame carries the locked channel
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == irpd_pkg::EV_ANALOG) |->
            (m_tdata[19:18] != '0) && (m_tdata[16:15] == m_tdata[19:18]))
        else $error("analog frame channel mismatch");
`endif

endmodule

`default_nettype wire

// ===== rtl/irpd_window_match.sv =====
// irpd_window_match: matches one edge gap against all nec and analog timing windows
// depends on irpd_pkg
`default_nettype none

module irpd_window_match (
    input  wire logic [irpd_pkg::GAP_W-1:0]  gap,
    input  wire logic [irpd_pkg::UNIT_W-1:0] nec_unit,
    input  wire logic [irpd_pkg::UNIT_W-1:0] ana_unit,
    output irpd_pkg::match_t                 hits
);

    logic [irpd_pkg::WIN_W-1:0] gap_w;
    logic [irpd_pkg::WIN_W-1:0] t1;
    logic [irpd_pkg::WIN_W-1:0] a1;
    logic [irpd_pkg::WIN_W-1:0] a_tol;

    assign gap_w = irpd_pkg::WIN_W'(gap);
    assign t1    = irpd_pkg::WIN_W'(nec_unit);
    assign a1    = irpd_pkg::WIN_W'(ana_unit);
    assign a_tol = a1 >> 1;

    // nominal lengths are shifts and one add of the unit
    assign hits.nec16 = irpd_pkg::nec_hit(gap_w, t1 << 4);
    assign hits.nec8  = irpd_pkg::nec_hit(gap_w, t1 << 3);
    assign hits.nec4  = irpd_pkg::nec_hit(gap_w, t1 << 2);
    assign hits.nec3  = irpd_pkg::nec_hit(gap_w, t1 + (t1 << 1));
    assign hits.nec1  = irpd_pkg::nec_hit(gap_w, t1);

    // analog windows, tolerance half a unit
    assign hits.ana3 = irpd_pkg::win_hit(gap_w, a1 + (a1 << 1), a_tol);
    assign hits.ana2 = irpd_pkg::win_hit(gap_w, a1 << 1, a_tol);
    assign hits.ana1 = irpd_pkg::win_hit(gap_w, a1, a_tol);

endmodule

`default_nettype wire

// ===== tb/tb_ir_remote_pulse_decoder.sv =====
// tb_ir_remote_pulse_decoder: self-checking bench for the ir remote pulse decoder
// drives timestamped edge requests, predicts every result in a scoreboard class
// depends on irpd_pkg and ir_remote_pulse_decoder
`timescale 1ns / 100ps

module tb_ir_remote_pulse_decoder;

    localparam int ANALOG_BITS = 15;
    localparam int EDGE_GOAL   = 850;
    localparam int CFG_SETS    = 5;

    // indexes past the register map, writes there must be dropped
    localparam logic [irpd_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [irpd_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    // one expected result of an edge request
    typedef struct packed {
        logic                        accepted;
        logic                        expect_rising;
        logic [irpd_pkg::EV_W-1:0]   ev;
        logic [irpd_pkg::CODE_W-1:0] code;
        logic [irpd_pkg::CHAN_W-1:0] channel;
    } edge_result_t;

    // decoder shadow plus the queue of results still owed by the block
    class ir_decode_tracker;
        logic [irpd_pkg::UNIT_W-1:0]  nec_unit;
        logic [irpd_pkg::UNIT_W-1:0]  ana_unit;
        logic [irpd_pkg::TIME_W-1:0]  last_us;
        irpd_pkg::phase_t             phase;
        logic [irpd_pkg::SHIFT_W-1:0] shifter;
        logic [irpd_pkg::CNT_W-1:0]   half_bits;
        logic [irpd_pkg::CODE_W-1:0]  held;
        logic [irpd_pkg::CHAN_W-1:0]  locked;
        edge_result_t                 owed_q[$];
        int unsigned                  errors;

        function new();
            nec_unit  = irpd_pkg::NEC_UNIT_RST;
            ana_unit  = irpd_pkg::ANA_UNIT_RST;
            last_us   = '0;
            phase     = irpd_pkg::PH_H_IDLE;
            shifter   = '0;
            half_bits = '0;
            held      = '0;
            locked    = '0;
            errors    = 0;
        endfunction

        function void write_reg(logic [irpd_pkg::CFG_IDX_W-1:0] idx,
                                logic [irpd_pkg::UNIT_W-1:0] val);
            case (idx)
                irpd_pkg::REG_NEC_UNIT: nec_unit = val;
                irpd_pkg::REG_ANA_UNIT: ana_unit = val;
                default: ;
            endcase
        endfunction

        function logic want_rising();
            return (phase == irpd_pkg::PH_L_HDR) || (phase == irpd_pkg::PH_L_BIT) ||
                   (phase == irpd_pkg::PH_L_ANA);
        endfunction

        // nec window: nominal d, tolerance d/4 + 1
        function bit in_nec(logic [irpd_pkg::GAP_W-1:0] gap, int unsigned mult);
            int unsigned d;
            int unsigned q;
            d = nec_unit * mult;
            q = (d >> 2) + 1;
            return (gap + q >= d) && (gap <= d + q);
        endfunction

        // analog window: nominal d, tolerance half a unit
        function bit in_ana(logic [irpd_pkg::GAP_W-1:0] gap, int unsigned mult);
            int unsigned d;
            int unsigned t;
            d = ana_unit * mult;
            t = ana_unit >> 1;
            return (gap + t >= d) && (gap <= d + t);
        endfunction

        // advance the shadow decoder by one accepted edge request
        function void note_edge(logic rise, logic [irpd_pkg::TIME_W-1:0] stamp);
            logic [irpd_pkg::TIME_W-1:0] span;
            logic [irpd_pkg::GAP_W-1:0]  gap;
            logic [15:0]                 frame;
            edge_result_t                r;
            bit                          hit;
            r = '0;
            r.ev = irpd_pkg::EV_NONE;
            if (rise == want_rising())
            begin
                span = stamp - last_us;
                gap = (span >= 32'h0001_0000) ? 16'hFFFF : span[irpd_pkg::GAP_W-1:0];
                r.accepted = 1'b1;
                last_us = stamp;
                case (phase)
                    irpd_pkg::PH_L_HDR:
                    begin
                        if (in_nec(gap, 16))
                            phase = irpd_pkg::PH_H_HDR;
                        else if (in_ana(gap, 3))
                        begin
                            shifter = '0;
                            half_bits = '0;
                            phase = irpd_pkg::PH_H_ANA;
                        end
                        else
                            phase = irpd_pkg::PH_H_IDLE;
                    end
                    irpd_pkg::PH_H_HDR:
                    begin
                        phase = irpd_pkg::PH_H_IDLE;
                        if (in_nec(gap, 8))
                        begin
                            shifter = '0;
                            half_bits = '0;
                            phase = irpd_pkg::PH_L_BIT;
                        end
                        else if (in_nec(gap, 4) && held != 0)
                            r.ev = irpd_pkg::EV_REPEAT;
                    end
                    irpd_pkg::PH_L_BIT:
                    begin
                        phase = irpd_pkg::PH_H_IDLE;
                        if (in_nec(gap, 1))
                        begin
                            if (half_bits < irpd_pkg::NEC_FRAME_BITS)
                                phase = irpd_pkg::PH_H_BIT;
                            else if ((((shifter >> 8) ^ shifter) & irpd_pkg::NEC_CPL_MASK)
                                     == irpd_pkg::NEC_CPL_MASK)
                            begin
                                held = {8'h00, shifter[23:16]};
                                r.ev = irpd_pkg::EV_NEC;
                            end
                        end
                    end
                    irpd_pkg::PH_H_BIT:
                    begin
                        phase = irpd_pkg::PH_L_BIT;
                        shifter = shifter >> 1;
                        half_bits = half_bits + 1'b1;
                        if (in_nec(gap, 3))
                            shifter[31] = 1'b1;
                        else if (!in_nec(gap, 1))
                            phase = irpd_pkg::PH_H_IDLE;
                    end
                    irpd_pkg::PH_H_ANA, irpd_pkg::PH_L_ANA:
                    begin
                        hit = 1'b1;
                        if (in_ana(gap, 1))
                        begin
                            if (!half_bits[0])
                                shifter = {shifter[irpd_pkg::SHIFT_W-2:0], 1'b1};
                            half_bits = half_bits + 1'b1;
                        end
                        else if (in_ana(gap, 2))
                        begin
                            shifter = shifter << 1;
                            half_bits = half_bits + 2'd2;
                        end
                        else
                        begin
                            hit = 1'b0;
                            phase = irpd_pkg::PH_H_IDLE;
                        end
                        if (hit && half_bits < 2 * ANALOG_BITS)
                            phase = (phase == irpd_pkg::PH_L_ANA) ? irpd_pkg::PH_H_ANA
                                                                 : irpd_pkg::PH_L_ANA;
                        else if (hit)
                        begin
                            // first nonzero channel locks, later frames must match it
                            frame = shifter[15:0];
                            if (locked == 0)
                                locked = frame[14:13];
                            else if (frame[14:13] == locked)
                            begin
                                held = frame;
                                r.ev = irpd_pkg::EV_ANALOG;
                            end
                            phase = irpd_pkg::PH_H_IDLE;
                        end
                    end
                    default: phase = irpd_pkg::PH_L_HDR;
                endcase
            end
            r.expect_rising = want_rising();
            r.code = held;
            r.channel = locked;
            owed_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                if (errors < 40)
                    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [23:0] data, logic [irpd_pkg::EV_W-1:0] user);
            edge_result_t want;
            if (owed_q.size() == 0)
            begin
                if (errors < 40)
                    $display("%0t: result with no request pending, expected none, actual %h/%h",
                             $time, data, user);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            compare_field("accepted", 16'(want.accepted), 16'(data[0]));
            compare_field("expect_rising", 16'(want.expect_rising), 16'(data[1]));
            compare_field("code", want.code, data[17:2]);
            compare_field("channel", 16'(want.channel), 16'(data[19:18]));
            compare_field("pad", 16'h0000, 16'(data[23:20]));
            compare_field("event", 16'(want.ev), 16'(user));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [11:0] cfg_wdata = '0;

    ir_decode_tracker tracker = new();

    int unsigned                 edges_taken = 0;
    int unsigned                 tx_idle_pct = 37;
    int unsigned                 rx_idle_pct = 73;
    bit                          rx_hold_req = 1'b0;
    int unsigned                 rx_hold_left = 0;
    logic [irpd_pkg::TIME_W-1:0] now_us = '0;
    int unsigned                 analog_sent = 0;

    ir_remote_pulse_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    // run limit
    initial
    begin
        #(2_000_000);
        $display("ir_remote_pulse_decoder regression: fail");
        $finish;
    end

    // result side: random stalls plus a single long hold-off in the first pass
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                rx_hold_left = 300;
            end
            if (rx_hold_left != 0)
            begin
                m_tready <= 1'b0;
                rx_hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_result(m_tdata, m_tuser);
    end

    // offer one edge request and hold it until taken
    task automatic send_edge(input logic rise, input logic [irpd_pkg::TIME_W-1:0] stamp);
        edges_taken++;
        if (edges_taken < EDGE_GOAL / 3)
        begin
            tx_idle_pct = 37;
            rx_idle_pct = 73;
        end
        else if (edges_taken < 2 * EDGE_GOAL / 3)
        begin
            tx_idle_pct = 73;
            rx_idle_pct = 37;
        end
        else
        begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= stamp;
        s_tuser <= rise;
        do
            @(posedge clk);
        while (!s_tready);
        tracker.note_edge(rise, stamp);
        now_us = stamp;
    endtask

    task automatic edge_after(input logic rise, input int unsigned gap);
        send_edge(rise, now_us + gap);
    endtask

    // stop offering and wait for every owed result
    task automatic wait_drained();
        int unsigned waited;
        waited = 0;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (tracker.owed_q.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [irpd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [irpd_pkg::UNIT_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        tracker.write_reg(idx, val);
    endtask

    // gap around nominal d: mostly inside the window, edges included; sloppy adds misses
    function automatic int unsigned pick_gap(int unsigned d, int unsigned tol, bit sloppy);
        int unsigned r;
        r = $urandom_range(99);
        if (sloppy && r < 8)
            return d + tol + 1;
        if (sloppy && r < 14)
            return (d > tol) ? d - tol - 1 : d + 2 * tol + 2;
        if (sloppy && r < 18)
            return $urandom_range(70000);
        if (r < 28)
            return d - tol;
        if (r < 38)
            return d + tol;
        return $urandom_range(d + tol, d - tol);
    endfunction

    function automatic int unsigned nec_gap(int unsigned mult, bit sloppy);
        int unsigned d;
        d = tracker.nec_unit * mult;
        return pick_gap(d, (d >> 2) + 1, sloppy);
    endfunction

    function automatic int unsigned ana_gap(int unsigned mult, bit sloppy);
        return pick_gap(tracker.ana_unit * mult, tracker.ana_unit >> 1, sloppy);
    endfunction

    // quiet line before a frame, often long enough to saturate
    function automatic int unsigned idle_gap();
        if ($urandom_range(99) < 40)
            return $urandom_range(400000, 65536);
        return $urandom_range(30000);
    endfunction

    // nec frame: header, 32 bits lsb first, closing low
    task automatic nec_frame(input bit sloppy);
        logic [7:0]  addr;
        logic [7:0]  cmd;
        logic [31:0] word;
        addr = 8'($urandom);
        cmd = ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom);
        word = {~cmd, cmd, ~addr, addr};
        if ($urandom_range(9) == 0)
            word = word ^ (32'h1 << $urandom_range(31));
        edge_after(1'b0, idle_gap());
        edge_after(1'b1, nec_gap(16, sloppy));
        edge_after(1'b0, nec_gap(8, sloppy));
        for (int i = 0; i < 32; i++)
        begin
            edge_after(1'b1, nec_gap(1, sloppy));
            edge_after(1'b0, nec_gap(word[i] ? 3 : 1, sloppy));
        end
        edge_after(1'b1, nec_gap(1, sloppy));
    endtask

    task automatic nec_repeat(input bit sloppy);
        edge_after(1'b0, idle_gap());
        edge_after(1'b1, nec_gap(16, sloppy));
        edge_after(1'b0, nec_gap(4, sloppy));
    endtask

    // analog frame: 3A header, then a one as two 1A pulses, a zero as one 2A pulse
    task automatic analog_frame(input logic [1:0] ch, input bit sloppy);
        logic [14:0] word;
        logic        pol;
        word = {ch, 13'($urandom)};
        edge_after(1'b0, idle_gap());
        edge_after(1'b1, ana_gap(3, sloppy));
        pol = 1'b0;
        for (int i = 14; i >= 0; i--)
        begin
            if (word[i])
            begin
                edge_after(pol, ana_gap(1, sloppy));
                pol = ~pol;
                edge_after(pol, ana_gap(1, sloppy));
            end
            else
                edge_after(pol, ana_gap(2, sloppy));
            pol = ~pol;
        end
        analog_sent++;
    endtask

    // random edges of either polarity, with jumps anywhere on the time line
    task automatic line_noise(input int unsigned count);
        int unsigned r;
        repeat (count)
        begin
            r = $urandom_range(99);
            if (r < 20)
                send_edge(1'($urandom), $urandom);
            else if (r < 50)
                edge_after(1'($urandom), $urandom_range(70000));
            else
                edge_after(1'($urandom), $urandom_range(20000));
        end
    endtask

    initial
    begin
        logic [irpd_pkg::UNIT_W-1:0] nec_set[CFG_SETS];
        logic [irpd_pkg::UNIT_W-1:0] ana_set[CFG_SETS];
        logic [1:0]                  ch;
        bit                          sloppy;
        bit                          paused;
        int unsigned                 r;

        nec_set = '{12'd562, 12'd4095, 12'd1, 12'($urandom_range(1500, 100)), 12'd1};
        ana_set = '{12'd350, 12'd1, 12'd4095, 12'($urandom_range(1200, 100)), 12'd1};
        paused = 1'b0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // unused indexes first, they must leave the units alone
        write_reg(REG_SPARE_LO, 12'($urandom));
        write_reg(REG_SPARE_HI, 12'hFFF);
        write_reg(irpd_pkg::REG_NEC_UNIT, nec_set[0]);
        write_reg(irpd_pkg::REG_ANA_UNIT, ana_set[0]);

        // directed edges at the reset units (nec 16T 8992, 4T 2248, analog 3A 1050)
        send_edge(1'b1, 32'd5);            // rising while idle is ignored
        send_edge(1'b0, 32'd0);            // zero gap, header low starts
        send_edge(1'b1, 32'hFFFF_FFFF);    // gap saturates, misses every window
        send_edge(1'b0, 32'h0000_0010);    // timestamp wraps past zero
        edge_after(1'b0, 100);             // falling while rising expected: ignored
        edge_after(1'b1, 8992);            // nec header low
        edge_after(1'b0, 2248);            // repeat with nothing held: no event
        edge_after(1'b0, 70000);
        edge_after(1'b1, 1050);            // analog header
        edge_after(1'b0, 5000);            // window miss back to idle
        edge_after(1'b0, 123);
        edge_after(1'b1, 6742);            // one below the 16T window
        edge_after(1'b0, 9);
        edge_after(1'b1, 6743);            // low edge of the 16T window
        edge_after(1'b0, 5622);            // one above the 8T window
        send_edge(1'b0, 32'hA5A5_5A5A);
        edge_after(1'b1, 11241);           // high edge of the 16T window
        edge_after(1'b0, 2811);            // high edge of the 4T window
        send_edge(1'b1, 32'h5A5A_A5A5);    // ignored, idle wants falling

        // random part, one unit setting per pass
        for (int p = 0; p < CFG_SETS; p++)
        begin
            if (p != 0)
            begin
                wait_drained();
                write_reg(irpd_pkg::REG_NEC_UNIT, nec_set[p]);
                write_reg(irpd_pkg::REG_ANA_UNIT, ana_set[p]);
            end
            if (p == 0)
                rx_hold_req = 1'b1;
            while (edges_taken < (p + 1) * EDGE_GOAL / CFG_SETS)
            begin
                sloppy = ($urandom_range(4) == 0);
                r = $urandom_range(99);
                if (r < 35)
                    nec_frame(sloppy);
                else if (r < 55)
                    nec_repeat(sloppy);
                else if (r < 85)
                begin
                    // first analog frame on channel zero must not lock
                    if (analog_sent == 0)
                        ch = 2'd0;
                    else if (tracker.locked != 0 && $urandom_range(3) != 0)
                        ch = tracker.locked;
                    else
                        ch = 2'($urandom);
                    analog_frame(ch, sloppy);
                end
                else
                    line_noise($urandom_range(6, 1));
                if (p == 2 && !paused && edges_taken >= 5 * EDGE_GOAL / 2 / CFG_SETS)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end

        wait_drained();
        if (tracker.owed_q.size() != 0)
        begin
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, tracker.owed_q.size());
            tracker.errors++;
        end
        if (tracker.errors == 0)
            $display("ir_remote_pulse_decoder regression: pass");
        else
            $display("ir_remote_pulse_decoder regression: fail");
        $finish;
    end

endmodule
